// ===== hw/rtl/mmnc_pkg.sv =====
package mmnc_pkg;

	// Fraction bits of the normalized value (Q1.NORM_BITS)
	localparam int NORM_BITS = 16;

	localparam int SAMPLE_W = 16;
	localparam int RANGE_W  = 17;
	localparam int CFG_W    = 16;
	localparam int V_W      = NORM_BITS + 1;
	localparam int T_W      = NORM_BITS + 2;
	localparam int CNT_W    = $clog2(NORM_BITS);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [7:0]                 chan_t;
	typedef logic [RANGE_W-1:0]         range_t;

	typedef enum logic [1:0] {
		CFG_COLOR_SCHEME = 2'd0,
		CFG_MIN_RANGE    = 2'd1,
		CFG_FLAT_RANGE   = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		SCHEME_GRAY    = 2'd0,
		SCHEME_TERRAIN = 2'd1,
		SCHEME_TEMP    = 2'd2,
		SCHEME_EDGE    = 2'd3
	} scheme_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

endpackage

// ===== hw/rtl/mmnc_in_if.sv =====
interface mmnc_in_if import mmnc_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    mode;
	sample_t sample;
	logic    last;

	modport source (output valid, output mode, output sample, output last, input ready);
	modport sink   (input valid, input mode, input sample, input last, output ready);
endinterface

// ===== hw/rtl/mmnc_out_if.sv =====
interface mmnc_out_if import mmnc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  frame_end;

	modport source (output valid, output red, output green, output blue, output frame_end,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input frame_end,
		output ready);
endinterface

// ===== hw/rtl/min_max_normalize_colormap.sv =====
// Min-max normalizer with color map for a two-pass stream of signed Q3.12 samples. A
// statistics beat (mode 0) updates the running minimum and maximum and produces no pixel;
// with last set it latches the frame minimum and range (a range of zero or below min_range
// is replaced by flat_range, zero flat_range acts as one) and starts a new pass. A color
// beat (mode 1) produces exactly one pixel: the sample is normalized against the latched
// minimum and range with a restoring divider that resolves one quotient bit per cycle,
// then mapped through the selected scheme. A color beat passes through accept, a step that
// forms the difference and catches the clamped cases, NORM_BITS divider steps and a step
// that maps and loads the output register; ready stays low until the block is idle again.
// A sample whose difference is not positive, or reaches the range, skips the divider. The
// mapping step holds while the previous pixel has not been taken, so a stalled output
// lengthens the beat. The finished pixel waits in its own register, so the next sample is
// accepted while it is still pending. Write configuration only while the block is idle.
module min_max_normalize_colormap import mmnc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	mmnc_in_if.sink          samples,
	mmnc_out_if.source       pixels
);

	localparam logic [V_W-1:0] Q_ONE   = V_W'(1) << NORM_BITS;
	localparam logic [V_W-1:0] Q_QUART = Q_ONE >> 2;
	localparam logic [V_W-1:0] Q_HALF  = Q_ONE >> 1;
	localparam logic [V_W-1:0] Q_3QUART = Q_QUART + Q_HALF;
	localparam int P_W = T_W + 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_MAP
	} state_t;

	// (x * k) >> NORM_BITS, low eight bits kept
	function automatic chan_t scale(logic [T_W-1:0] x, chan_t k);
		logic [P_W-1:0] prod;
		prod = P_W'(x) * P_W'(k);
		return prod[NORM_BITS +: 8];
	endfunction

	function automatic rgb_t color_map(scheme_t sch, logic [V_W-1:0] v);
		logic [T_W-1:0] t;
		logic [P_W-1:0] prod;
		rgb_t c;
		t = '0;
		prod = '0;
		c = '{red: 8'd0, green: 8'd0, blue: 8'd0};
		case (sch)
			SCHEME_TERRAIN: begin
				if (v < Q_QUART) begin
					t = T_W'(v) << 2;
					c = '{red: 8'd0, green: scale(t, 8'd255), blue: 8'd255};
				end else if (v < Q_HALF) begin
					t = (T_W'(v) - T_W'(Q_QUART)) << 2;
					c = '{red: 8'd0, green: 8'd255, blue: scale(T_W'(Q_ONE) - t, 8'd255)};
				end else if (v < Q_3QUART) begin
					t = (T_W'(v) - T_W'(Q_HALF)) << 2;
					c = '{red: scale(t, 8'd255), green: 8'd255, blue: 8'd0};
				end else begin
					t = (T_W'(v) - T_W'(Q_3QUART)) << 2;
					prod = P_W'((T_W'(Q_ONE) << 1) - t) * P_W'(8'd255);
					c = '{red: 8'd255, green: prod[NORM_BITS+1 +: 8], blue: scale(t, 8'd255)};
				end
			end
			SCHEME_TEMP: begin
				if (v < Q_HALF) begin
					t = T_W'(v) << 1;
					c = '{red: 8'd0, green: scale(t, 8'd200), blue: 8'd255};
				end else begin
					t = (T_W'(v) - T_W'(Q_HALF)) << 1;
					c = '{red: scale(t, 8'd255), green: 8'd200 + scale(t, 8'd55),
						blue: scale(T_W'(Q_ONE) - t, 8'd255)};
				end
			end
			default: begin
				// grayscale and edge distance
				c.red   = scale(T_W'(v), 8'd255);
				c.green = c.red;
				c.blue  = c.red;
			end
		endcase
		return c;
	endfunction

	state_t             st_q;
	scheme_t            scheme_q;
	logic [CFG_W-1:0]   min_range_q;
	logic [CFG_W-1:0]   flat_range_q;

	sample_t            running_min_q;
	sample_t            running_max_q;
	logic               pass_started_q;
	sample_t            frame_min_q;
	range_t             frame_range_q;

	sample_t            sample_q;
	logic               last_q;
	range_t             rem_q;
	logic [V_W-1:0]     v_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	rgb_t               pix_q;
	logic               frame_end_q;

	logic               accept;
	sample_t            new_min;
	sample_t            new_max;
	range_t             stat_range;
	logic               stat_flat;
	range_t             latch_range;
	range_t             den;
	logic signed [RANGE_W-1:0] diff;
	logic [RANGE_W:0]   rem_dbl;
	logic               rem_ge;
	logic               out_free;

	assign samples.ready = (st_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || pixels.ready;

	// Running statistics including the beat being accepted
	always_comb begin
		new_min = samples.sample;
		new_max = samples.sample;
		if (pass_started_q) begin
			new_min = (samples.sample < running_min_q) ? samples.sample : running_min_q;
			new_max = (samples.sample > running_max_q) ? samples.sample : running_max_q;
		end
		stat_range  = RANGE_W'({new_max[SAMPLE_W-1], new_max} - {new_min[SAMPLE_W-1], new_min});
		stat_flat   = (stat_range == '0) || (stat_range < RANGE_W'(min_range_q));
		latch_range = stat_range;
		if (stat_flat) begin
			latch_range = (flat_range_q == '0) ? RANGE_W'(1) : RANGE_W'(flat_range_q);
		end
	end

	// Divider datapath: one compare-and-subtract per step
	assign den     = (frame_range_q == '0) ? RANGE_W'(1) : frame_range_q;
	assign diff    = {sample_q[SAMPLE_W-1], sample_q} - {frame_min_q[SAMPLE_W-1], frame_min_q};
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = (rem_dbl >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			scheme_q       <= SCHEME_GRAY;
			min_range_q    <= CFG_W'(1);
			flat_range_q   <= CFG_W'(4096);
			running_min_q  <= '0;
			running_max_q  <= '0;
			pass_started_q <= 1'b0;
			frame_min_q    <= '0;
			frame_range_q  <= RANGE_W'(4096);
			out_valid_q    <= 1'b0;
			cnt_q          <= '0;
			sample_q       <= '0;
			last_q         <= 1'b0;
			rem_q          <= '0;
			v_q            <= '0;
			pix_q          <= '0;
			frame_end_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index_t'(cfg_index))
					CFG_COLOR_SCHEME: scheme_q     <= scheme_t'(cfg_data[1:0]);
					CFG_MIN_RANGE:    min_range_q  <= cfg_data;
					CFG_FLAT_RANGE:   flat_range_q <= cfg_data;
					default: ;
				endcase
			end

			// raise the pixel out of the mapping step, drop it once it is taken
			if (st_q == ST_MAP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						sample_q <= samples.sample;
						last_q   <= samples.last;
						if (samples.mode) begin
							st_q <= ST_SETUP;
						end else if (samples.last) begin
							// close the pass: latch bounds for the color pass
							frame_min_q    <= new_min;
							frame_range_q  <= latch_range;
							pass_started_q <= 1'b0;
							running_min_q  <= new_min;
							running_max_q  <= new_max;
						end else begin
							running_min_q  <= new_min;
							running_max_q  <= new_max;
							pass_started_q <= 1'b1;
						end
					end
				end
				ST_SETUP: begin
					rem_q <= RANGE_W'(diff);
					cnt_q <= '0;
					if (diff[RANGE_W-1] || diff == '0) begin
						v_q  <= '0;
						st_q <= ST_MAP;
					end else if (RANGE_W'(diff) >= den) begin
						// quotient reaches one: clamp
						v_q  <= Q_ONE;
						st_q <= ST_MAP;
					end else begin
						v_q  <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? RANGE_W'(rem_dbl - {1'b0, den}) : RANGE_W'(rem_dbl);
					v_q   <= {v_q[V_W-2:0], rem_ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NORM_BITS - 1)) begin
						st_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					// hold until the output register is free
					if (out_free) begin
						pix_q       <= color_map(scheme_q, v_q);
						frame_end_q <= last_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign pixels.valid     = out_valid_q;
	assign pixels.red       = pix_q.red;
	assign pixels.green     = pix_q.green;
	assign pixels.blue      = pix_q.blue;
	assign pixels.frame_end = frame_end_q;

`ifndef ASSERT_OFF
	// the divider remainder never reaches the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (rem_q < den))
		else $error("divider remainder out of range");

	// the latched range is never zero
	a_range_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_range_q != '0)
		else $error("frame range is zero");

	// a pixel appears only out of the mapping step
	a_valid_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_MAP))
		else $error("pixel raised outside the mapping step");

	// a color beat keeps the block busy on the next cycle
	a_color_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.mode) |=> !samples.ready)
		else $error("color beat did not occupy the block");
`endif

endmodule
